[rtl/core/atrp_pkg.sv]
package atrp_pkg;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 72;
    localparam int FIELD_W   = 16;

    // Angle arithmetic: accumulator in units where 2^31 equals pi
    localparam int     GUARD_BITS = 8;
    localparam int     ACC_W      = 33;
    localparam int     ANGLE_W    = 18;
    localparam int     ANGLE_FRAC = 16;
    localparam int     ROUND_HALF = 32768;
    localparam int     ANGLE_MAX  = 32768;
    localparam int     QUARTER    = 1073741824;
    localparam longint HALF_TURN  = 64'sd2147483648;

    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = 5;

    // atan(2^-i), 2^31 = pi
    localparam logic [29:0] ATAN_TAB [ATAN_DEPTH] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Item codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_MARK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [2:0] SNS_ACCEL = 3'd0;
    localparam logic [2:0] SNS_MAG   = 3'd1;
    localparam logic [2:0] SNS_EULER = 3'd2;

    localparam logic STS_OK      = 1'b0;
    localparam logic STS_REJECT  = 1'b1;

    // atan2 runs per accel item: (y,z), (ref_y,ref_z), (x,z), (ref_x,ref_z)
    localparam logic [1:0] RUN_ROLL     = 2'd0;
    localparam logic [1:0] RUN_ROLL_REF = 2'd1;
    localparam logic [1:0] RUN_PITCH    = 2'd2;
    localparam logic [1:0] RUN_LAST     = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       run_start;
        logic [1:0] run_sel;
        logic       run_store;
        logic       commit;
    } atrp_cmd_t;

    typedef struct packed {
        logic is_accel;
        logic run_done;
        logic out_free;
    } atrp_sts_t;

endpackage

[rtl/core/accel_tilt_roll_pitch.sv]
// Channel  Dir  tdata                                        tuser
// s_       in   acc_x, acc_y, acc_z, downstream_ok            action, sense
// m_       out  roll, pitch, dirty, update_count              status
//
// Accel push: the result comes from four back-to-back atan2 runs on the one shared
// CORDIC unit; a run ends early when its residual reaches zero. Every other item skips
// the runs and waits only for the output register to free up.
// One item at a time; the next is taken once the result sits in the output register.
// m_tready low stalls only the output register and, behind it, the next result.
// aresetn clears the reference, angles, flags and update count.
module accel_tilt_roll_pitch #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // acc_x [15:0], acc_y [31:16], acc_z [47:32], downstream_ok [48], zero [55:49]
    input  logic [atrp_pkg::S_TDATA_W-1:0]    s_tdata,
    // action [1:0], sense [4:2]
    input  logic [atrp_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // roll [17:0], pitch [35:18], dirty [36], update_count [68:37], zero [71:69]
    output logic [atrp_pkg::M_TDATA_W-1:0]    m_tdata,
    // status [0]
    output logic                              m_tuser
);
    import atrp_pkg::*;

    atrp_cmd_t cmd;
    atrp_sts_t sts;

    atrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atrp_datapath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

[rtl/core/atrp_cordic.sv]
module atrp_cordic #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [SAMPLE_BITS-1:0]         y_in,
    input  logic signed [SAMPLE_BITS-1:0]         x_in,
    output logic                                  done,
    output logic signed [atrp_pkg::ANGLE_W-1:0]   angle
);
    import atrp_pkg::*;

    localparam int W   = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int IW  = $clog2(CORDIC_STEPS + 1);
    localparam int AW1 = ACC_W + 1;

    logic signed [W-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [IW-1:0]             step_reg, step_next;
    logic                      busy_reg, busy_next, done_reg, done_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;

    logic signed [W-1:0]       xs, ys, dx, dy;
    logic signed [ACC_W-1:0]   tab;
    logic signed [AW1-1:0]     rnd, shf;
    logic signed [ANGLE_W-1:0] clamped;
    logic                      finish;

    always_comb begin
        xs  = W'(x_in) <<< GUARD_BITS;
        ys  = W'(y_in) <<< GUARD_BITS;
        dx  = y_reg >>> step_reg;
        dy  = x_reg >>> step_reg;
        tab = ACC_W'(ATAN_TAB[ATAN_IDX_W'(step_reg)]);
        // stop after the last step, or early once the residual is exactly zero
        finish = (step_reg == IW'(CORDIC_STEPS)) || (y_reg == '0);

        rnd = AW1'(acc_reg) + AW1'(ROUND_HALF);
        shf = rnd >>> ANGLE_FRAC;
        if (shf > AW1'(ANGLE_MAX)) begin
            clamped = ANGLE_W'(ANGLE_MAX);
        end else if (shf < -AW1'(ANGLE_MAX)) begin
            clamped = -ANGLE_W'(ANGLE_MAX);
        end else begin
            clamped = ANGLE_W'(shf);
        end
    end

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        if (start) begin
            step_next = '0;
            busy_next = 1'b1;
            if (y_in == '0) begin
                // on the axis: 0, or exactly pi for a negative x
                x_next   = xs;
                y_next   = '0;
                acc_next = x_in[SAMPLE_BITS-1] ? ACC_W'(HALF_TURN) : '0;
            end else if (x_in[SAMPLE_BITS-1]) begin
                // left half plane: pre-rotate by a quarter turn
                if (!y_in[SAMPLE_BITS-1]) begin
                    x_next   = ys;
                    y_next   = -xs;
                    acc_next = ACC_W'(QUARTER);
                end else begin
                    x_next   = -ys;
                    y_next   = xs;
                    acc_next = -ACC_W'(QUARTER);
                end
            end else begin
                x_next   = xs;
                y_next   = ys;
                acc_next = '0;
            end
        end else if (busy_reg) begin
            if (finish) begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                angle_next = clamped;
            end else begin
                step_next = step_reg + 1'b1;
                if (!y_reg[W-1]) begin
                    x_next   = x_reg + dx;
                    y_next   = y_reg - dy;
                    acc_next = acc_reg + tab;
                end else begin
                    x_next   = x_reg - dx;
                    y_next   = y_reg + dy;
                    acc_next = acc_reg - tab;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

[rtl/core/atrp_ctrl.sv]
module atrp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  atrp_pkg::atrp_sts_t   sts,
    output atrp_pkg::atrp_cmd_t   cmd
);
    import atrp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_POST  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] run_reg, run_next;

    always_comb begin
        state_next = state_reg;
        run_next   = run_reg;
        cmd        = '0;
        cmd.run_sel = run_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.is_accel) begin
                        run_next   = '0;
                        state_next = ST_START;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_START: begin
                cmd.run_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.run_done) begin
                    cmd.run_store = 1'b1;
                    if (run_reg == RUN_LAST) begin
                        state_next = ST_POST;
                    end else begin
                        run_next   = run_reg + 2'd1;
                        state_next = ST_START;
                    end
                end
            end
            ST_POST: begin
                // wait for the output register to free up
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            run_reg   <= '0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

[rtl/core/atrp_datapath.sv]
module atrp_datapath #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [atrp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [atrp_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [atrp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    input  atrp_pkg::atrp_cmd_t               cmd,
    output atrp_pkg::atrp_sts_t               sts
);
    import atrp_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [1:0]                in_act;
    logic [2:0]                in_sense;
    logic signed [SB-1:0]      in_x, in_y, in_z;

    logic [1:0]                item_act_reg;
    logic [2:0]                item_sense_reg;
    logic                      item_ok_reg;
    logic signed [SB-1:0]      item_x_reg, item_y_reg, item_z_reg;
    logic signed [SB-1:0]      ref_x_reg, ref_y_reg, ref_z_reg;
    logic                      zero_pend_reg;
    logic                      unread_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg;
    logic [31:0]               count_reg;
    logic signed [ANGLE_W-1:0] part_reg, roll_new_reg, pitch_new_reg;
    logic                      out_valid_reg;
    logic [M_TDATA_W-1:0]      out_data_reg;
    logic                      out_status_reg;

    logic signed [SB-1:0]      op_y, op_x;
    logic                      run_done;
    logic signed [ANGLE_W-1:0] run_angle;

    logic                      status_next, dirty_next, mark_next;
    logic signed [ANGLE_W-1:0] roll_next, pitch_next;
    logic [31:0]               count_next;

    // tuser: action [1:0], sense [4:2]
    // tdata: acc_x [15:0], acc_y [31:16], acc_z [47:32], downstream_ok [48]
    assign in_act   = s_tuser[1:0];
    assign in_sense = s_tuser[4:2];
    assign in_x     = signed'(SB'(s_tdata[FIELD_W-1:0]));
    assign in_y     = signed'(SB'(s_tdata[2*FIELD_W-1:FIELD_W]));
    assign in_z     = signed'(SB'(s_tdata[3*FIELD_W-1:2*FIELD_W]));

    always_comb begin
        case (cmd.run_sel)
            RUN_ROLL:     begin op_y = item_y_reg; op_x = item_z_reg; end
            RUN_ROLL_REF: begin op_y = ref_y_reg;  op_x = ref_z_reg;  end
            RUN_PITCH:    begin op_y = item_x_reg; op_x = item_z_reg; end
            default:      begin op_y = ref_x_reg;  op_x = ref_z_reg;  end
        endcase
    end

    atrp_cordic #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.run_start),
        .y_in    (op_y),
        .x_in    (op_x),
        .done    (run_done),
        .angle   (run_angle)
    );

    always_comb begin
        status_next = STS_OK;
        roll_next   = roll_reg;
        pitch_next  = pitch_reg;
        dirty_next  = unread_reg;
        count_next  = count_reg;
        mark_next   = 1'b0;
        unique case (item_act_reg)
            ACT_PUSH: begin
                unique case (item_sense_reg) inside
                    SNS_ACCEL: begin
                        roll_next  = roll_new_reg;
                        pitch_next = pitch_new_reg;
                        count_next = count_reg + 32'd1;
                        // a set flag stays until read
                        dirty_next = unread_reg | !item_ok_reg;
                    end
                    SNS_MAG, SNS_EULER: status_next = STS_OK;
                    default:            status_next = STS_REJECT;
                endcase
            end
            ACT_MARK: mark_next   = 1'b1;
            ACT_READ: dirty_next  = 1'b0;
            default:  status_next = STS_REJECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            ref_z_reg     <= '0;
            zero_pend_reg <= 1'b0;
            unread_reg    <= 1'b0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept && sts.is_accel && zero_pend_reg) begin
                ref_x_reg     <= in_x;
                ref_y_reg     <= in_y;
                ref_z_reg     <= in_z;
                zero_pend_reg <= 1'b0;
            end
            if (cmd.commit) begin
                if (mark_next) begin
                    zero_pend_reg <= 1'b1;
                end
                unread_reg    <= dirty_next;
                roll_reg      <= roll_next;
                pitch_reg     <= pitch_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_act_reg   <= in_act;
            item_sense_reg <= in_sense;
            item_ok_reg    <= s_tdata[3*FIELD_W];
            item_x_reg     <= in_x;
            item_y_reg     <= in_y;
            item_z_reg     <= in_z;
        end
        if (cmd.run_store) begin
            if (!cmd.run_sel[0]) begin
                part_reg <= run_angle;
            end else if (!cmd.run_sel[1]) begin
                roll_new_reg <= part_reg - run_angle;
            end else begin
                pitch_new_reg <= part_reg - run_angle;
            end
        end
        if (cmd.commit) begin
            out_status_reg <= status_next;
            out_data_reg   <= {3'b000, count_next, dirty_next, pitch_next, roll_next};
        end
    end

    assign sts.is_accel = (in_act == ACT_PUSH) && (in_sense == SNS_ACCEL);
    assign sts.run_done = run_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

[rtl/core/atrp_checker.sv]
module atrp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [atrp_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);
    import atrp_pkg::*;

    logic                      out_acc;
    logic signed [ANGLE_W-1:0] roll, pitch;
    logic [31:0]               cnt;
    logic signed [ANGLE_W-1:0] last_roll_reg, last_pitch_reg;
    logic [31:0]               last_cnt_reg;

    assign out_acc = m_tvalid && m_tready;
    assign roll    = m_tdata[ANGLE_W-1:0];
    assign pitch   = m_tdata[2*ANGLE_W-1:ANGLE_W];
    assign cnt     = m_tdata[2*ANGLE_W+32:2*ANGLE_W+1];

    // last delivered item, starting from the reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
            last_cnt_reg   <= '0;
        end else if (out_acc) begin
            last_roll_reg  <= roll;
            last_pitch_reg <= pitch;
            last_cnt_reg   <= cnt;
        end
    end

    ap_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output item changed");

    ap_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in flight");

    ap_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (cnt == last_cnt_reg) || (cnt == last_cnt_reg + 32'd1))
        else $error("update count skipped");

    ap_reject_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_tuser |->
            (roll == last_roll_reg) && (pitch == last_pitch_reg) && (cnt == last_cnt_reg))
        else $error("rejected item changed the angles or count");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

[dv/tilt_checker.sv]
`timescale 1ns / 100ps

module tilt_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // acc_x [15:0], acc_y [31:16], acc_z [47:32], downstream_ok [48], zero [55:49]
    input  logic [atrp_pkg::S_TDATA_W-1:0] s_tdata,
    // action [1:0], sense [4:2]
    input  logic [atrp_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // roll [17:0], pitch [35:18], dirty [36], update_count [68:37], zero [71:69]
    input  logic [atrp_pkg::M_TDATA_W-1:0] m_tdata,
    // status [0]
    input  logic                           m_tuser,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    import atrp_pkg::*;

    localparam int     STEPS        = 16;
    localparam int     GUARD        = 8;
    localparam longint QUARTER_TURN = 64'sd1073741824;

    typedef struct packed {
        logic        status;
        logic [17:0] roll;
        logic [17:0] pitch;
        logic        dirty;
        logic [31:0] updates;
    } tilt_result_t;

    // level reference and stored angles
    longint       level_x, level_y, level_z;
    logic         capture_armed;
    logic         unread;
    int           roll_now, pitch_now;
    logic [31:0]  update_total;

    tilt_result_t angles_due[$];
    int           mismatches;
    int           compared;

    // atan(2^-i), 2^31 = pi
    function automatic longint arctan_step(int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    // atan2(y, x) as a binary angle, 32768 = pi
    function automatic int bam_atan2(longint y, longint x);
        longint acc;
        longint t;
        longint dx, dy;
        acc = 0;
        if (y == 0)
            return (x < 0) ? 32768 : 0;
        x = x * (64'sd1 <<< GUARD);
        y = y * (64'sd1 <<< GUARD);
        // fold left half-plane into the right one
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t;
                acc = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y == 0)
                break;
            if (y > 0) begin
                x = x + dx; y = y - dy; acc = acc + arctan_step(i);
            end else begin
                x = x - dx; y = y + dy; acc = acc - arctan_step(i);
            end
        end
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > 32768)
            acc = 32768;
        if (acc < -32768)
            acc = -32768;
        return int'(acc);
    endfunction

    function automatic tilt_result_t tilt_after_item(logic [S_TUSER_W-1:0] user,
                                                     logic [S_TDATA_W-1:0] data);
        logic [1:0]   act;
        logic [2:0]   sns;
        longint       x, y, z;
        tilt_result_t r;
        act = user[1:0];
        sns = user[4:2];
        x = longint'($signed(data[15:0]));
        y = longint'($signed(data[31:16]));
        z = longint'($signed(data[47:32]));
        r.status = STS_OK;
        case (act)
            ACT_PUSH: begin
                if (sns == SNS_ACCEL) begin
                    if (capture_armed) begin
                        level_x = x; level_y = y; level_z = z;
                        capture_armed = 1'b0;
                    end
                    roll_now  = bam_atan2(y, z) - bam_atan2(level_y, level_z);
                    pitch_now = bam_atan2(x, z) - bam_atan2(level_x, level_z);
                    update_total = update_total + 32'd1;
                    // sticky until read
                    if (!data[48])
                        unread = 1'b1;
                end else if (sns != SNS_MAG && sns != SNS_EULER) begin
                    r.status = STS_REJECT;
                end
            end
            ACT_MARK: capture_armed = 1'b1;
            ACT_READ: unread = 1'b0;
            default:  r.status = STS_REJECT;
        endcase
        r.roll    = roll_now[17:0];
        r.pitch   = pitch_now[17:0];
        r.dirty   = unread;
        r.updates = update_total;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        tilt_result_t want;
        tilt_result_t got;
        if (!aresetn) begin
            level_x = 0; level_y = 0; level_z = 0;
            capture_armed = 1'b0;
            unread = 1'b0;
            roll_now = 0;
            pitch_now = 0;
            update_total = '0;
            angles_due.delete();
        end else begin
            // output side first: a result never leaves in the edge its item enters
            if (m_tvalid && m_tready) begin
                got.status  = m_tuser;
                got.roll    = m_tdata[17:0];
                got.pitch   = m_tdata[35:18];
                got.dirty   = m_tdata[36];
                got.updates = m_tdata[68:37];
                if (angles_due.size() == 0) begin
                    $error("result item with no input item waiting for it");
                    mismatches++;
                end else begin
                    want = angles_due.pop_front();
                    compared++;
                    check_field("status", want.status, got.status);
                    check_field("roll", $signed(want.roll), $signed(got.roll));
                    check_field("pitch", $signed(want.pitch), $signed(got.pitch));
                    check_field("dirty", want.dirty, got.dirty);
                    check_field("update_count", want.updates, got.updates);
                end
            end
            if (s_tvalid && s_tready)
                angles_due.push_back(tilt_after_item(s_tuser, s_tdata));
        end
        errors  <= mismatches;
        pending <= angles_due.size();
        checked <= compared;
    end

endmodule

[dv/accel_tilt_roll_pitch_tb.sv]
`timescale 1ns / 100ps

module accel_tilt_roll_pitch_tb;
    import atrp_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
    localparam logic [2:0] SNS_GYRO     = 3'd3;
    localparam logic [2:0] SNS_UNITLESS = 3'd4;
    localparam logic [2:0] SNS_TOP      = 3'd7;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         SETTLE       = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int   errors, pending, checked;
    logic rx_calm = 1'b0;
    bit   tx_calm;
    int   rx_hold;
    int   idle_cycles;
    int   accel_sent, marks_sent, reads_sent, other_sent, sent;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    accel_tilt_roll_pitch i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tilt_checker u_tilt_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // result side: random stall after each accepted item
    always @(posedge aclk) begin : rx_side
        int stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            rx_hold  <= stall;
            m_tready <= (stall == 0);
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic [1:0] act, logic [2:0] sns,
                             logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic ok);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ok, z, y, x};
        s_tuser  <= {sns, act};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_PUSH && sns == SNS_ACCEL)
            accel_sent++;
        else if (act == ACT_MARK)
            marks_sent++;
        else if (act == ACT_READ)
            reads_sent++;
        else
            other_sent++;
        sent++;
    endtask

    // hold the input side until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            4: return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int pick;
        logic [15:0] x, y, z;
        pick = $urandom_range(0, 99);
        x = pick_sample();
        y = pick_sample();
        z = pick_sample();
        if (pick < 68)
            send_item(ACT_PUSH, SNS_ACCEL, x, y, z, $urandom_range(0, 3) != 0);
        else if (pick < 76)
            send_item(ACT_MARK, 3'($urandom), x, y, z, 1'($urandom));
        else if (pick < 86)
            send_item(ACT_READ, 3'($urandom), x, y, z, 1'($urandom));
        else if (pick < 91)
            send_item(ACT_PUSH, 3'($urandom_range(SNS_MAG, SNS_EULER)), x, y, z,
                      1'($urandom));
        else if (pick < 96)
            send_item(ACT_PUSH, 3'($urandom_range(SNS_GYRO, SNS_TOP)), x, y, z,
                      1'($urandom));
        else
            send_item(ACT_UNKNOWN, 3'($urandom), x, y, z, 1'($urandom));
    endtask

    initial begin
        int goal;
        accel_sent = 0; marks_sent = 0; reads_sent = 0; other_sent = 0; sent = 0;
        tx_calm = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero vector, atan2 of zero over negative, exact 45 degree stop
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0000, 16'h0000, 16'h8000, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0064, 16'h0064, 16'hFF9C, 1'b1);
        // downstream rejects: dirty sets and survives the next good push
        send_item(ACT_PUSH, SNS_ACCEL, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h1234, 16'hEDCB, 16'h4000, 1'b1);
        send_item(ACT_READ, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        // level capture on the push after a mark
        send_item(ACT_MARK, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0064, 16'hFF38, 16'h012C, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // non-accel pushes and unknown codes
        send_item(ACT_PUSH, SNS_MAG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_PUSH, SNS_EULER, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        send_item(ACT_PUSH, SNS_GYRO, 16'h0001, 16'h0002, 16'h0003, 1'b1);
        send_item(ACT_PUSH, SNS_UNITLESS, 16'h0001, 16'h0002, 16'h0003, 1'b0);
        send_item(ACT_PUSH, SNS_TOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_UNKNOWN, SNS_TOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // double mark, then z = 0 vector
        send_item(ACT_MARK, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_item(ACT_MARK, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 1'b0);
        send_item(ACT_PUSH, SNS_ACCEL, 16'h0001, 16'hFFFF, 16'h8000, 1'b1);
        send_item(ACT_READ, SNS_ACCEL, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        goal = sent;
        for (int phase = 0; phase < 5; phase++) begin
            tx_calm = (phase == 2);
            rx_calm <= (phase == 2);
            goal += 86;
            while (sent < goal)
                random_item();
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        $display("Sent %0d items: %0d accel pushes, %0d level marks, %0d reads, %0d other.",
                 accel_sent + marks_sent + reads_sent + other_sent,
                 accel_sent, marks_sent, reads_sent, other_sent);
        $display("Compared %0d results; random gaps and stalls on both sides, one quiet phase.",
                 checked);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[accel_tilt_roll_pitch.f]
rtl/core/atrp_pkg.sv
rtl/core/atrp_cordic.sv
rtl/core/atrp_ctrl.sv
rtl/core/atrp_datapath.sv
rtl/core/accel_tilt_roll_pitch.sv
rtl/core/atrp_checker.sv
dv/tilt_checker.sv
dv/accel_tilt_roll_pitch_tb.sv
